@@ src/nearest_box_per_direction_defines.svh @@
// Assertion macros used by the checker of the nearest box block.
// Depends on nothing; users supply the clock and reset signals named below.
`ifndef NEAREST_BOX_PER_DIRECTION_DEFINES_SVH
`define NEAREST_BOX_PER_DIRECTION_DEFINES_SVH

// Checked on every rising clock edge outside of reset.
`define NBPD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define NBPD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ src/nbpd_pkg.sv @@
// Package for the nearest box per direction block: types and constants.
// Used by every RTL module and by the checker; depends on nothing.
`timescale 1ns / 1ps

package nbpd_pkg;

   localparam int COORD_W = 16;
   localparam int SIZE_W  = 15;
   localparam int KIND_W  = 4;
   localparam int GAP_W   = 14;
   localparam int NUM_DIR = 4;

   // Gap value that means no box was found in a direction.
   localparam logic [GAP_W-1:0] NO_GAP = 14'd10000;

   // Configuration register indexes.
   localparam logic [1:0] CSR_REF_X = 2'd0;
   localparam logic [1:0] CSR_REF_Y = 2'd1;
   localparam logic [1:0] CSR_REF_W = 2'd2;
   localparam logic [1:0] CSR_REF_H = 2'd3;

   typedef enum logic [1:0] {
      DIR_LEFT  = 2'd0,
      DIR_RIGHT = 2'd1,
      DIR_UP    = 2'd2,
      DIR_DOWN  = 2'd3
   } dir_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [SIZE_W-1:0]  w;
      logic [SIZE_W-1:0]  h;
   } box_type;

   // Outcome of classifying one box against the reference.
   typedef struct packed {
      logic             hit;
      dir_type          dir;
      logic [GAP_W-1:0] gap;
   } hit_type;

endpackage

@@ src/nearest_box_per_direction.sv @@
// Top level of the nearest box per direction block.
// Instantiates nbpd_classify and nbpd_minima; depends on nbpd_pkg.
`timescale 1ns / 1ps

// The block takes one candidate box word per clock while req_stall is low and
// reports, once per scan, the nearest box to the left, right, above and below a
// reference box held in the csr_ registers. A box counts for a direction only if
// it lies wholly on that side and overlaps the reference on the other axis; gaps
// of 10000 or more are ignored, and a tie keeps the first box. When the word
// carrying req_last_box is processed, one rsp_ word appears with the four minima
// (10000 and type 0 where nothing was found), and the minima restart for the
// next scan. A word sits in the input register, where classification and the
// minimum update complete, and its result is loaded into the output register,
// which drives rsp_valid. req_stall rises only when a last word waits in the
// input register while the output register still holds a result that the
// receiver stalls. Write the reference registers only while no scan is in
// flight.
module nearest_box_per_direction
   import nbpd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      csr_write_en,
   input  logic [1:0]                csr_index,
   input  logic [COORD_W-1:0]        csr_wdata,

   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [COORD_W-1:0] req_box_x,
   input  logic signed [COORD_W-1:0] req_box_y,
   input  logic [SIZE_W-1:0]         req_box_w,
   input  logic [SIZE_W-1:0]         req_box_h,
   input  logic [KIND_W-1:0]         req_box_kind,
   input  logic                      req_last_box,

   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [GAP_W-1:0]          rsp_left_gap,
   output logic [KIND_W-1:0]         rsp_left_kind,
   output logic [GAP_W-1:0]          rsp_right_gap,
   output logic [KIND_W-1:0]         rsp_right_kind,
   output logic [GAP_W-1:0]          rsp_up_gap,
   output logic [KIND_W-1:0]         rsp_up_kind,
   output logic [GAP_W-1:0]          rsp_down_gap,
   output logic [KIND_W-1:0]         rsp_down_kind
);

   // Reference box registers.
   box_type ref_ff;

   // Input register.
   logic              in_valid_ff;
   box_type           in_box_ff;
   logic [KIND_W-1:0] in_kind_ff;
   logic              in_last_ff;

   // Result register.
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [NUM_DIR-1:0][GAP_W-1:0]  rsp_gap_ff;
   logic [NUM_DIR-1:0][KIND_W-1:0] rsp_kind_ff;

   logic                           advance;
   logic                           step;
   logic                           req_take;
   hit_type                        hit;
   logic [NUM_DIR-1:0][GAP_W-1:0]  res_gap;
   logic [NUM_DIR-1:0][KIND_W-1:0] res_kind;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_REF_X: ref_ff.x <= csr_wdata;
            CSR_REF_Y: ref_ff.y <= csr_wdata;
            CSR_REF_W: ref_ff.w <= csr_wdata[SIZE_W-1:0];
            CSR_REF_H: ref_ff.h <= csr_wdata[SIZE_W-1:0];
            default: ref_ff <= ref_ff;
         endcase
      end
   end

   // The word in the input register moves on unless it must deliver a result
   // and the output register is full and stalled.
   assign advance   = !(in_valid_ff && in_last_ff && rsp_valid_ff && rsp_stall);
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_box_ff.x <= req_box_x;
         in_box_ff.y <= req_box_y;
         in_box_ff.w <= req_box_w;
         in_box_ff.h <= req_box_h;
         in_kind_ff  <= req_box_kind;
         in_last_ff  <= req_last_box;
      end
   end

   nbpd_classify u_classify (
      .ref_box  (ref_ff),
      .cand_box (in_box_ff),
      .hit      (hit)
   );

   nbpd_minima u_minima (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .hit      (hit),
      .kind     (in_kind_ff),
      .last     (in_last_ff),
      .res_gap  (res_gap),
      .res_kind (res_kind)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (step && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && in_last_ff) begin
         rsp_gap_ff  <= res_gap;
         rsp_kind_ff <= res_kind;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_left_gap   = rsp_gap_ff[DIR_LEFT];
   assign rsp_left_kind  = rsp_kind_ff[DIR_LEFT];
   assign rsp_right_gap  = rsp_gap_ff[DIR_RIGHT];
   assign rsp_right_kind = rsp_kind_ff[DIR_RIGHT];
   assign rsp_up_gap     = rsp_gap_ff[DIR_UP];
   assign rsp_up_kind    = rsp_kind_ff[DIR_UP];
   assign rsp_down_gap   = rsp_gap_ff[DIR_DOWN];
   assign rsp_down_kind  = rsp_kind_ff[DIR_DOWN];

endmodule

@@ src/nbpd_classify.sv @@
// Direction and gap of one candidate box relative to the reference box.
// Pure combinational logic; depends on nbpd_pkg.
`timescale 1ns / 1ps

module nbpd_classify
   import nbpd_pkg::*;
(
   input  box_type ref_box,
   input  box_type cand_box,
   output hit_type hit
);

   localparam int EXT_W = COORD_W + 2;

   logic signed [EXT_W-1:0] rx, ry, rx_end, ry_end;
   logic signed [EXT_W-1:0] bx, by, bx_end, by_end;
   logic                    x_overlap, y_overlap;
   logic                    found;
   dir_type                 dir;
   logic signed [EXT_W-1:0] raw_gap;

   always_comb begin
      rx     = EXT_W'($signed(ref_box.x));
      ry     = EXT_W'($signed(ref_box.y));
      bx     = EXT_W'($signed(cand_box.x));
      by     = EXT_W'($signed(cand_box.y));
      rx_end = rx + $signed({3'b000, ref_box.w});
      ry_end = ry + $signed({3'b000, ref_box.h});
      bx_end = bx + $signed({3'b000, cand_box.w});
      by_end = by + $signed({3'b000, cand_box.h});

      y_overlap = (by_end > ry) && (by < ry_end);
      x_overlap = (bx_end > rx) && (bx < rx_end);

      // Later tests win, so down beats up and right beats left when a
      // degenerate box meets two opposite tests.
      found   = 1'b0;
      dir     = DIR_LEFT;
      raw_gap = '0;
      if (bx_end <= rx && y_overlap) begin
         found   = 1'b1;
         dir     = DIR_LEFT;
         raw_gap = rx - bx_end;
      end
      if (bx >= rx_end && y_overlap) begin
         found   = 1'b1;
         dir     = DIR_RIGHT;
         raw_gap = bx - rx_end;
      end
      if (by_end <= ry && x_overlap) begin
         found   = 1'b1;
         dir     = DIR_UP;
         raw_gap = ry - by_end;
      end
      if (by >= ry_end && x_overlap) begin
         found   = 1'b1;
         dir     = DIR_DOWN;
         raw_gap = by - ry_end;
      end

      // The gap is never negative once a direction is found; far boxes are dropped.
      hit.hit = found && (raw_gap < $signed({{(EXT_W-GAP_W){1'b0}}, NO_GAP}));
      hit.dir = dir;
      hit.gap = raw_gap[GAP_W-1:0];
   end

endmodule

@@ src/nbpd_minima.sv @@
// Running minimum gap and its type code for each of the four directions.
// Cleared by reset and after every last box; depends on nbpd_pkg.
`timescale 1ns / 1ps

module nbpd_minima
   import nbpd_pkg::*;
(
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             step,
   input  hit_type                          hit,
   input  logic [KIND_W-1:0]                kind,
   input  logic                             last,
   output logic [NUM_DIR-1:0][GAP_W-1:0]    res_gap,
   output logic [NUM_DIR-1:0][KIND_W-1:0]   res_kind
);

   logic [NUM_DIR-1:0][GAP_W-1:0]  min_gap_ff, min_gap_in;
   logic [NUM_DIR-1:0][KIND_W-1:0] min_kind_ff, min_kind_in;

   always_comb begin
      for (int d = 0; d < NUM_DIR; d++) begin
         res_gap[d]  = min_gap_ff[d];
         res_kind[d] = min_kind_ff[d];
         // A gap equal to the stored minimum keeps the earlier box.
         if (hit.hit && hit.dir == dir_type'(d) && hit.gap < min_gap_ff[d]) begin
            res_gap[d]  = hit.gap;
            res_kind[d] = kind;
         end
         min_gap_in[d]  = last ? NO_GAP : res_gap[d];
         min_kind_in[d] = last ? '0 : res_kind[d];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < NUM_DIR; d++) begin
            min_gap_ff[d]  <= NO_GAP;
            min_kind_ff[d] <= '0;
         end
      end else if (step) begin
         min_gap_ff  <= min_gap_in;
         min_kind_ff <= min_kind_in;
      end
   end

endmodule

@@ src/nbpd_checker.sv @@
// Port-level checks of the nearest box per direction block, bound to its top.
// Depends on nbpd_pkg and nearest_box_per_direction_defines.svh.
`timescale 1ns / 1ps
`include "nearest_box_per_direction_defines.svh"

module nbpd_checker
   import nbpd_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [GAP_W-1:0]          rsp_left_gap,
   input logic [KIND_W-1:0]         rsp_left_kind,
   input logic [GAP_W-1:0]          rsp_right_gap,
   input logic [KIND_W-1:0]         rsp_right_kind,
   input logic [GAP_W-1:0]          rsp_up_gap,
   input logic [KIND_W-1:0]         rsp_up_kind,
   input logic [GAP_W-1:0]          rsp_down_gap,
   input logic [KIND_W-1:0]         rsp_down_kind
);

   // A stalled result word stays valid, with its left gap and down type code unchanged.
   `NBPD_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_left_gap) && $stable(rsp_down_kind), "stalled result word changed")

   // No reported gap exceeds the no-box value.
   `NBPD_ASSERT(a_gap_range, rsp_valid |-> (rsp_left_gap <= NO_GAP) && (rsp_right_gap <= NO_GAP) && (rsp_up_gap <= NO_GAP) && (rsp_down_gap <= NO_GAP), "reported gap above the no-box value")

   // A direction with no box found reports type code zero.
   `NBPD_ASSERT(a_empty_kind, rsp_valid |-> (rsp_left_gap != NO_GAP || rsp_left_kind == '0) && (rsp_right_gap != NO_GAP || rsp_right_kind == '0) && (rsp_up_gap != NO_GAP || rsp_up_kind == '0) && (rsp_down_gap != NO_GAP || rsp_down_kind == '0), "empty direction with a nonzero type code")

   // Reset leaves no result pending.
   `NBPD_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_valid, "result valid right after reset")

endmodule

bind nearest_box_per_direction nbpd_checker u_nbpd_checker (.*);
